[rtl/cst_pkg.sv]
// Shared types, codes and helper functions for the character stream tokenizer.
`default_nettype none

package cst_pkg;

  // Field widths of the token outputs.
  localparam int LEN_BITS = 8;
  localparam int VAL_BITS = 32;
  localparam int KIND_BITS = 5;
  // Most tokens one source byte can produce.
  localparam int MAX_TOKS = 3;

  // Token kind codes.
  localparam logic [KIND_BITS-1:0] K_LPAREN  = 5'd0;
  localparam logic [KIND_BITS-1:0] K_RPAREN  = 5'd1;
  localparam logic [KIND_BITS-1:0] K_EQUAL   = 5'd2;
  localparam logic [KIND_BITS-1:0] K_COMMA   = 5'd3;
  localparam logic [KIND_BITS-1:0] K_TICK    = 5'd4;
  localparam logic [KIND_BITS-1:0] K_BTICK   = 5'd5;
  localparam logic [KIND_BITS-1:0] K_SEMI    = 5'd6;
  localparam logic [KIND_BITS-1:0] K_DOT     = 5'd7;
  localparam logic [KIND_BITS-1:0] K_HASH    = 5'd8;
  localparam logic [KIND_BITS-1:0] K_LBRACK  = 5'd9;
  localparam logic [KIND_BITS-1:0] K_RBRACK  = 5'd10;
  localparam logic [KIND_BITS-1:0] K_LBRACE  = 5'd11;
  localparam logic [KIND_BITS-1:0] K_RBRACE  = 5'd12;
  localparam logic [KIND_BITS-1:0] K_MINUS   = 5'd13;
  localparam logic [KIND_BITS-1:0] K_PLUS    = 5'd14;
  localparam logic [KIND_BITS-1:0] K_STAR    = 5'd15;
  localparam logic [KIND_BITS-1:0] K_PERCENT = 5'd16;
  localparam logic [KIND_BITS-1:0] K_LT      = 5'd17;
  localparam logic [KIND_BITS-1:0] K_GT      = 5'd18;
  localparam logic [KIND_BITS-1:0] K_COLON   = 5'd19;
  localparam logic [KIND_BITS-1:0] K_QUEST   = 5'd20;
  localparam logic [KIND_BITS-1:0] K_PIPE    = 5'd21;
  localparam logic [KIND_BITS-1:0] K_AMP     = 5'd22;
  localparam logic [KIND_BITS-1:0] K_CARET   = 5'd23;
  localparam logic [KIND_BITS-1:0] K_SLASH   = 5'd24;
  localparam logic [KIND_BITS-1:0] K_INT     = 5'd25;
  localparam logic [KIND_BITS-1:0] K_IDENT   = 5'd26;
  localparam logic [KIND_BITS-1:0] K_STRING  = 5'd27;
  localparam logic [KIND_BITS-1:0] K_UNKNOWN = 5'd28;
  localparam logic [KIND_BITS-1:0] K_EOF     = 5'd29;

  // Character constants.
  localparam logic [7:0] CH_NUL       = 8'h00;
  localparam logic [7:0] CH_TAB       = 8'h09;
  localparam logic [7:0] CH_LF        = 8'h0A;
  localparam logic [7:0] CH_CR        = 8'h0D;
  localparam logic [7:0] CH_SPACE     = 8'h20;
  localparam logic [7:0] CH_QUOTE     = 8'h22;
  localparam logic [7:0] CH_HASH      = 8'h23;
  localparam logic [7:0] CH_SLASH     = 8'h2F;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_BTICK     = 8'h60;

  // Scan modes.
  typedef enum logic [6:0] {
    M_IDLE    = 7'b0000001,
    M_INT     = 7'b0000010,
    M_IDENT   = 7'b0000100,
    M_STR     = 7'b0001000,
    M_COMMENT = 7'b0010000,
    M_SLASH   = 7'b0100000,
    M_DONE    = 7'b1000000
  } mode_t;

  // One input byte.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } in_t;

  // One token.
  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [LEN_BITS-1:0]  length;
    logic [VAL_BITS-1:0]  value;
    logic                 unclosed;
    logic                 last_of_run;
  } out_t;

  // All tokens caused by one byte, in order, with their count.
  typedef struct packed {
    out_t [MAX_TOKS-1:0] toks;
    logic [1:0]          count;
  } batch_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDERSCORE);
  endfunction

  function automatic logic is_eol(input logic [7:0] c);
    return (c == CH_CR) || (c == CH_LF) || (c == CH_NUL);
  endfunction

  // Single-character punctuation: hit flag and kind.
  function automatic logic [KIND_BITS:0] punct_kind(input logic [7:0] c);
    logic [KIND_BITS:0] r;
    r = {1'b1, K_UNKNOWN};
    case (c)
      8'h28:    r[KIND_BITS-1:0] = K_LPAREN;
      8'h29:    r[KIND_BITS-1:0] = K_RPAREN;
      8'h3D:    r[KIND_BITS-1:0] = K_EQUAL;
      8'h2C:    r[KIND_BITS-1:0] = K_COMMA;
      8'h27:    r[KIND_BITS-1:0] = K_TICK;
      CH_BTICK: r[KIND_BITS-1:0] = K_BTICK;
      8'h3B:    r[KIND_BITS-1:0] = K_SEMI;
      8'h2E:    r[KIND_BITS-1:0] = K_DOT;
      CH_HASH:  r[KIND_BITS-1:0] = K_HASH;
      8'h5B:    r[KIND_BITS-1:0] = K_LBRACK;
      8'h5D:    r[KIND_BITS-1:0] = K_RBRACK;
      8'h7B:    r[KIND_BITS-1:0] = K_LBRACE;
      8'h7D:    r[KIND_BITS-1:0] = K_RBRACE;
      8'h2D:    r[KIND_BITS-1:0] = K_MINUS;
      8'h2B:    r[KIND_BITS-1:0] = K_PLUS;
      8'h2A:    r[KIND_BITS-1:0] = K_STAR;
      8'h25:    r[KIND_BITS-1:0] = K_PERCENT;
      8'h3C:    r[KIND_BITS-1:0] = K_LT;
      8'h3E:    r[KIND_BITS-1:0] = K_GT;
      8'h3A:    r[KIND_BITS-1:0] = K_COLON;
      8'h3F:    r[KIND_BITS-1:0] = K_QUEST;
      8'h7C:    r[KIND_BITS-1:0] = K_PIPE;
      8'h26:    r[KIND_BITS-1:0] = K_AMP;
      8'h5E:    r[KIND_BITS-1:0] = K_CARET;
      default:  r[KIND_BITS] = 1'b0;
    endcase
    return r;
  endfunction

  // Saturating length increment.
  function automatic logic [LEN_BITS-1:0] len_inc(input logic [LEN_BITS-1:0] l);
    return (l == {LEN_BITS{1'b1}}) ? l : l + 1'b1;
  endfunction

  // Saturating decimal accumulate: v * 10 + d, built from shifts and adds.
  function automatic logic [VAL_BITS-1:0] val_acc(input logic [VAL_BITS-1:0] v,
                                                  input logic [3:0] d);
    logic [VAL_BITS+3:0] w;
    w = ({4'b0, v} << 3) + ({4'b0, v} << 1) + (VAL_BITS+4)'(d);
    return (w[VAL_BITS+3:VAL_BITS] != 4'b0) ? {VAL_BITS{1'b1}} : w[VAL_BITS-1:0];
  endfunction

  function automatic out_t mk_tok(input logic [KIND_BITS-1:0] kind,
                                  input logic [LEN_BITS-1:0] len,
                                  input logic [VAL_BITS-1:0] val,
                                  input logic unc);
    out_t t;
    t.kind        = kind;
    t.length      = len;
    t.value       = val;
    t.unclosed    = unc;
    t.last_of_run = 1'b0;
    return t;
  endfunction

endpackage

`default_nettype wire

[rtl/cst_scan.sv]
// Scan state registers and the per-byte token generation logic.
`default_nettype none

module cst_scan (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           step,
  input  wire cst_pkg::in_t   in_data,
  output cst_pkg::batch_t     batch
);
  import cst_pkg::*;

  mode_t                mode_r, mode_nxt;
  logic [LEN_BITS-1:0]  len_r, len_nxt;
  logic [VAL_BITS-1:0]  val_r, val_nxt;

  // Candidate tokens in output order: ended token, token from the new
  // byte, flushed token at end of file, end-of-file token.
  out_t [3:0] cand;
  logic [3:0] cand_vld;
  logic       do_idle;
  logic [KIND_BITS:0] pk;
  logic [7:0] c;

  assign c  = in_data.ch;
  assign pk = punct_kind(c);

  // Next scan state and candidate tokens.
  always_comb begin
    mode_nxt = mode_r;
    len_nxt  = len_r;
    val_nxt  = val_r;
    cand     = '0;
    cand_vld = '0;
    do_idle  = 1'b0;
    if (step && (mode_r != M_DONE)) begin
      case (mode_r)
        M_INT: begin
          if (is_digit(c)) begin
            len_nxt = len_inc(len_r);
            val_nxt = val_acc(val_r, c[3:0]);
          end else if (is_word(c)) begin
            mode_nxt = M_IDENT;
            val_nxt  = '0;
            len_nxt  = len_inc(len_r);
          end else begin
            cand[0]     = mk_tok(K_INT, len_r, val_r, 1'b0);
            cand_vld[0] = 1'b1;
            do_idle     = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_word(c) || is_digit(c)) begin
            len_nxt = len_inc(len_r);
          end else begin
            cand[0]     = mk_tok(K_IDENT, len_r, '0, 1'b0);
            cand_vld[0] = 1'b1;
            do_idle     = 1'b1;
          end
        end
        M_STR: begin
          if ((c == CH_QUOTE) || is_eol(c)) begin
            cand[0]     = mk_tok(K_STRING, len_r, '0, is_eol(c));
            cand_vld[0] = 1'b1;
            mode_nxt    = M_IDLE;
            len_nxt     = '0;
          end else begin
            len_nxt = len_inc(len_r);
          end
        end
        M_COMMENT: begin
          if (is_eol(c)) begin
            mode_nxt = M_IDLE;
          end
        end
        M_SLASH: begin
          if (c == CH_SLASH) begin
            mode_nxt = M_COMMENT;
          end else begin
            cand[0]     = mk_tok(K_SLASH, LEN_BITS'(1), '0, 1'b0);
            cand_vld[0] = 1'b1;
            do_idle     = 1'b1;
          end
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Start of a new token from the idle mode.
      if (do_idle) begin
        mode_nxt = M_IDLE;
        len_nxt  = '0;
        val_nxt  = '0;
        if ((c == CH_SPACE) || (c == CH_TAB) || is_eol(c)) begin
          mode_nxt = M_IDLE;
        end else if (c == CH_SLASH) begin
          mode_nxt = M_SLASH;
        end else if (pk[KIND_BITS]) begin
          cand[1]     = mk_tok(pk[KIND_BITS-1:0], LEN_BITS'(1), '0, 1'b0);
          cand_vld[1] = 1'b1;
        end else if (is_digit(c)) begin
          mode_nxt = M_INT;
          len_nxt  = LEN_BITS'(1);
          val_nxt  = VAL_BITS'(c[3:0]);
        end else if (is_word(c)) begin
          mode_nxt = M_IDENT;
          len_nxt  = LEN_BITS'(1);
        end else if (c == CH_QUOTE) begin
          mode_nxt = M_STR;
        end else begin
          cand[1]     = mk_tok(K_UNKNOWN, LEN_BITS'(1), '0, 1'b0);
          cand_vld[1] = 1'b1;
        end
      end

      // Final byte: flush the pending token, then end of file.
      if (in_data.last) begin
        case (mode_nxt)
          M_INT: begin
            cand[2]     = mk_tok(K_INT, len_nxt, val_nxt, 1'b0);
            cand_vld[2] = 1'b1;
          end
          M_IDENT: begin
            cand[2]     = mk_tok(K_IDENT, len_nxt, '0, 1'b0);
            cand_vld[2] = 1'b1;
          end
          M_STR: begin
            cand[2]     = mk_tok(K_STRING, len_nxt, '0, 1'b1);
            cand_vld[2] = 1'b1;
          end
          M_SLASH: begin
            cand[2]     = mk_tok(K_SLASH, LEN_BITS'(1), '0, 1'b0);
            cand_vld[2] = 1'b1;
          end
          default: begin
            cand_vld[2] = 1'b0;
          end
        endcase
        cand[3]     = mk_tok(K_EOF, '0, '0, 1'b0);
        cand_vld[3] = 1'b1;
        mode_nxt    = M_DONE;
        len_nxt     = '0;
        val_nxt     = '0;
      end
    end
  end

  // Pack the valid candidates in order and mark the final one.
  always_comb begin
    logic [1:0] n;
    n     = 2'd0;
    batch = '0;
    for (int i = 0; i < 4; i++) begin
      if (cand_vld[i] && (n != 2'd3)) begin
        batch.toks[n] = cand[i];
        n = n + 2'd1;
      end
    end
    for (int k = 0; k < MAX_TOKS; k++) begin
      batch.toks[k].last_of_run = (2'(k + 1) == n);
    end
    batch.count = n;
  end

  // Scan state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_IDLE;
      len_r  <= '0;
      val_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
      val_r  <= val_nxt;
    end
  end

  // Once end of file is sent, no byte yields a token.
  a_done_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (mode_r == M_DONE)) |-> (batch.count == 2'd0))
    else $error("token produced after end of file");

  // The idle mode holds no partial token.
  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == M_IDLE) |-> ((len_r == '0) && (val_r == '0)))
    else $error("idle mode with leftover token state");

  // A final byte always closes the stream.
  a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
    (step && in_data.last) |=> (mode_r == M_DONE))
    else $error("final byte did not end the stream");

endmodule

`default_nettype wire

[rtl/char_stream_tokenizer_top.sv]
// Top level of the character stream tokenizer: handshakes and result buffer.
// The first token of a byte is offered in the cycle after the byte is accepted.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is not stalled; a byte that yields more than one token (up to three) holds the input
// until the single result port has drained the per-byte token buffer to its last token.
// Reset: synchronous active-low rst_n returns the scanner to idle and empties the buffer.
`default_nettype none

module char_stream_tokenizer_top (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire cst_pkg::in_t in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output cst_pkg::out_t  out_data
);
  import cst_pkg::*;

  batch_t              batch;
  out_t [MAX_TOKS-1:0] toks_r;
  logic [1:0]          cnt_r;
  logic                in_fire;
  logic                out_fire;

  // Take a new byte while the buffer is empty or empties this cycle.
  assign in_ready  = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = toks_r[0];

  cst_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (in_fire),
    .in_data (in_data),
    .batch   (batch)
  );

  // Result buffer: loaded with all tokens of a byte, shifted out one per transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (in_fire) begin
      cnt_r <= batch.count;
    end else if (out_fire) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      toks_r <= batch.toks;
    end else if (out_fire) begin
      toks_r[0] <= toks_r[1];
      toks_r[1] <= toks_r[2];
    end
  end

  // The head token is the final one of its byte exactly when one remains.
  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != 2'd0) |-> (toks_r[0].last_of_run == (cnt_r == 2'd1)))
    else $error("last_of_run does not match buffer count");

  // End of file is always the final token of its byte.
  a_eof_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_data.kind == K_EOF)) |-> out_data.last_of_run)
    else $error("end of file is not the final token");

  // Draining one of several tokens leaves the next one offered.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && !in_fire && (cnt_r > 2'd1)) |=> out_valid)
    else $error("buffered token lost");

endmodule

`default_nettype wire
